// ===== rtl/tt_pkg.sv =====
package tt_pkg;

    localparam int SETS      = 1024;
    localparam int WAYS      = 4;
    localparam int NODE_BITS = 16;

    localparam int  SET_W     = $clog2(SETS);
    localparam int  WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int  NODE_W    = (NODE_BITS < 16) ? NODE_BITS : 16;
    localparam bit  SETS_POW2 = ((SETS & (SETS - 1)) == 0);

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [63:0] key;
        logic [3:0]         transform_in;
        logic [15:0]        node_in;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [1:0]  way_out;
        logic [3:0]  transform_out;
        logic [15:0] node_out;
        logic        took_free_slot;
        logic [31:0] live_count;
        logic [31:0] eviction_count;
    } t_out;

    typedef struct packed {
        logic [63:0]       key;
        logic [3:0]        tr;
        logic [NODE_W-1:0] node;
        logic [31:0]       lu;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    typedef struct packed {
        logic             done;
        logic [SET_W-1:0] set;
    } t_idx;

    typedef struct packed {
        logic             found;
        logic [WAY_W-1:0] hit_way;
        logic [WAY_W-1:0] best_way;
        logic             best_empty;
    } t_scan;

endpackage

// ===== rtl/set_assoc_transposition_table.sv =====
// Channel  Dir  Handshake                   Payload
// in       in   i_in_valid / o_in_stall     i_in_data  (t_in)
// out      out  o_out_valid / i_out_stall   o_out_data (t_out)
// cfg      in   i_cfg_valid / o_cfg_ready   i_cfg_data (time_slowdown)
//
// Steps per item: the idle state takes the beat, HASH forms the set index and reads the row
// (a mask when SETS is a power of two, else a reduction modulo SETS), SCAN passes one way
// per cycle through the shared compare unit, and WRITE writes the row back.
// Reset: a clearing pass writes every row empty with the input stalled; configuration
// writes are taken throughout. Stalls: a result waits in the output register while the next
// beat is taken; write-back waits only if it is still full.
module set_assoc_transposition_table
    import tt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Latched request
    logic [1:0]        r_op;
    logic [63:0]       r_key;
    logic [3:0]        r_tr;
    logic [NODE_W-1:0] r_node;

    // Table-wide state
    logic [15:0]      r_slowdown;
    logic [31:0]      r_time, n_time;
    logic [15:0]      r_presc, n_presc;
    logic [31:0]      r_live, n_live;
    logic [31:0]      r_evict, n_evict;
    logic [SET_W-1:0] r_clr_cnt;
    logic [WAY_W-1:0] r_way;

    logic r_out_valid;
    t_out r_out, n_out;

    logic accept, commit, clr_last, scan_last;
    logic [15:0] presc_inc;

    t_idx   idx;
    t_scan  scan;
    t_row   rd_row, wr_row, mem_wdata;
    t_entry hit_entry;
    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;

    assign accept    = i_in_valid && !o_in_stall;
    assign clr_last  = (r_clr_cnt == SET_W'(SETS - 1));
    assign scan_last = (r_way == WAY_W'(WAYS - 1));
    assign commit    = (r_state == S_WRITE) && (!r_out_valid || !i_out_stall);

    tt_set_index u_idx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   ($unsigned(i_in_data.key)),
        .o_idx   (idx)
    );

    tt_row_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    ((r_state == S_HASH) && idx.done),
        .i_raddr (idx.set),
        .o_rdata (rd_row)
    );

    tt_way_scan u_scan (
        .i_clk   (i_clk),
        .i_step  (r_state == S_SCAN),
        .i_init  (r_way == '0),
        .i_way   (r_way),
        .i_op    (r_op),
        .i_key   (r_key),
        .i_node  (r_node),
        .i_entry (rd_row[r_way]),
        .o_scan  (scan)
    );

    // Sequencer: clear rows after reset, then hash, scan ways, write back.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (clr_last) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_HASH;
            S_HASH:  if (idx.done) n_state = S_SCAN;
            S_SCAN:  if (scan_last) n_state = S_WRITE;
            S_WRITE: if (commit) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_way     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + SET_W'(1);
            end
            if (r_state == S_SCAN) begin
                r_way <= scan_last ? '0 : r_way + WAY_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_in_data.op;
            r_key  <= $unsigned(i_in_data.key);
            r_tr   <= i_in_data.transform_in;
            r_node <= i_in_data.node_in[NODE_W-1:0];
        end
    end

    // Prescaler and timestamp advance for an insert; the timestamp saturates.
    assign presc_inc = r_presc + 16'd1;

    always_comb begin
        n_presc = r_presc;
        n_time  = r_time;
        n_live  = r_live;
        n_evict = r_evict;
        if (r_op == OP_INSERT) begin
            n_presc = presc_inc;
            if (presc_inc == r_slowdown) begin
                n_presc = '0;
                if (r_time != TIME_MAX) begin
                    n_time = r_time + 32'd1;
                end
            end
            if (scan.best_empty) begin
                n_live = r_live + 32'd1;
            end else begin
                n_evict = r_evict + 32'd1;
            end
        end else if (r_op == OP_REMOVE && scan.found) begin
            n_live = r_live - 32'd1;
        end
    end

    // Build the row to write back and the result beat.
    assign hit_entry = rd_row[scan.hit_way];

    always_comb begin
        wr_row = rd_row;
        n_out  = '0;
        n_out.live_count     = n_live;
        n_out.eviction_count = n_evict;
        case (r_op)
            OP_LOOKUP: begin
                if (scan.found) begin
                    wr_row[scan.hit_way].lu = r_time;
                    n_out.hit           = 1'b1;
                    n_out.way_out       = 2'(scan.hit_way);
                    n_out.transform_out = hit_entry.tr;
                    n_out.node_out      = 16'(hit_entry.node);
                end
            end
            OP_INSERT: begin
                wr_row[scan.best_way].key  = r_key;
                wr_row[scan.best_way].tr   = r_tr;
                wr_row[scan.best_way].node = r_node;
                wr_row[scan.best_way].lu   = n_time;
                n_out.way_out        = 2'(scan.best_way);
                n_out.took_free_slot = scan.best_empty;
            end
            OP_REMOVE: begin
                if (scan.found) begin
                    wr_row[scan.hit_way].lu = 32'd0;
                    n_out.hit     = 1'b1;
                    n_out.way_out = 2'(scan.hit_way);
                end
            end
            default: begin
                // no operation: report the counters only
            end
        endcase
    end

    // Clearing pass writes empty rows; otherwise write back on commit.
    assign mem_we    = (r_state == S_CLEAR) || commit;
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_cnt : idx.set;
    assign mem_wdata = (r_state == S_CLEAR) ? t_row'('0) : wr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slowdown  <= 16'd1;
            r_time      <= 32'd1;
            r_presc     <= '0;
            r_live      <= '0;
            r_evict     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_slowdown <= i_cfg_data;
            end
            if (commit) begin
                r_time      <= n_time;
                r_presc     <= n_presc;
                r_live      <= n_live;
                r_evict     <= n_evict;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== rtl/tt_row_mem.sv =====
module tt_row_mem
    import tt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [SET_W-1:0] i_waddr,
    input  t_row             i_wdata,
    input  logic             i_re,
    input  logic [SET_W-1:0] i_raddr,
    output t_row             o_rdata
);

    t_row r_mem [SETS];
    t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tt_set_index.sv =====
module tt_set_index
    import tt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_key,
    output t_idx        o_idx
);

    generate
        if (SETS_POW2) begin : g_mask
            logic [SET_W-1:0] r_set;
            logic             r_done;

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_set <= i_key[SET_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else if (i_start) begin
                    r_done <= 1'b1;
                end
            end

            assign o_idx.done = r_done;
            assign o_idx.set  = r_set;
        end else begin : g_reduce
            localparam logic [SET_W:0] SETS_EXT = (SET_W + 1)'(SETS);

            logic [63:0]      r_key;
            logic [SET_W-1:0] r_rem;
            logic [SET_W-1:0] n_rem;
            logic [3:0]       r_cnt;
            logic             r_busy;
            logic             r_done;

            // Reduce four key bits per cycle, MSB first, one compare-subtract each.
            always_comb begin
                logic [SET_W:0]   v;
                logic [SET_W-1:0] t;
                t = r_rem;
                for (int j = 0; j < 4; j++) begin
                    v = {t, r_key[63-j]};
                    if (v >= SETS_EXT) begin
                        v = v - SETS_EXT;
                    end
                    t = v[SET_W-1:0];
                end
                n_rem = t;
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_key <= i_key;
                    r_rem <= '0;
                    r_cnt <= '0;
                end else if (r_busy) begin
                    r_key <= r_key << 4;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 4'd1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                end else if (i_start) begin
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                end else if (r_busy && r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end

            assign o_idx.done = r_done;
            assign o_idx.set  = r_rem;
        end
    endgenerate

endmodule

// ===== rtl/tt_way_scan.sv =====
module tt_way_scan
    import tt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_step,
    input  logic              i_init,
    input  logic [WAY_W-1:0]  i_way,
    input  logic [1:0]        i_op,
    input  logic [63:0]       i_key,
    input  logic [NODE_W-1:0] i_node,
    input  t_entry            i_entry,
    output t_scan             o_scan
);

    logic             r_found;
    logic [WAY_W-1:0] r_hit_way;
    logic [WAY_W-1:0] r_best_way;
    logic [31:0]      r_best_time;
    logic             match;

    // Live entry with equal key; remove also needs the node handle to agree.
    always_comb begin
        match = (i_entry.lu != 32'd0) && (i_entry.key == i_key);
        if (i_op == OP_REMOVE && i_entry.node != i_node) begin
            match = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (i_init) begin
                r_found     <= match;
                r_hit_way   <= i_way;
                r_best_way  <= i_way;
                r_best_time <= i_entry.lu;
            end else begin
                if (!r_found && match) begin
                    r_found   <= 1'b1;
                    r_hit_way <= i_way;
                end
                if (i_entry.lu < r_best_time) begin
                    r_best_way  <= i_way;
                    r_best_time <= i_entry.lu;
                end
            end
        end
    end

    assign o_scan.found      = r_found;
    assign o_scan.hit_way    = r_hit_way;
    assign o_scan.best_way   = r_best_way;
    assign o_scan.best_empty = (r_best_time == 32'd0);

endmodule

// ===== rtl/tt_checker.sv =====
module tt_assertions
    import tt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // Reset starts the clearing pass, which holds off input.
    a_clear_blocks: assert property (@(posedge i_clk) !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // An accepted beat keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a beat");

    // A result is loaded only at the end of an operation in flight.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no operation in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result beat changed");

endmodule

bind set_assoc_transposition_table tt_assertions u_tt_assertions (.*);
